>>> rtl/hmq_pkg.sv
// Shared constants and types for the binary min-heap queue.
// No dependencies; read first by every other file.
`timescale 1ns / 1ps

package hmq_pkg;

    localparam int DEPTH_DEF   = 64;
    localparam int VALUE_W     = 32;
    localparam int CAP_W       = 7;
    localparam int COUNT_W_DEF = $clog2(DEPTH_DEF + 1);

    localparam logic [CAP_W-1:0]          CAP_RESET = 7'd64;
    localparam logic signed [VALUE_W-1:0] INT_MIN   = 32'sh8000_0000;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

>>> rtl/hmq_if.sv
// Channel interfaces for the heap queue: operation input, result output, configuration.
// Depends on hmq_pkg.
`timescale 1ns / 1ps

interface hmq_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic signed [hmq_pkg::VALUE_W-1:0]    value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface hmq_out_if #(
    parameter int COUNT_W = hmq_pkg::COUNT_W_DEF
);
    logic                                  valid;
    logic                                  ready;
    logic signed [hmq_pkg::VALUE_W-1:0]    popped_value;
    hmq_pkg::t_status                      status;
    logic [COUNT_W-1:0]                    entries_after;

    modport source (output valid, output popped_value, output status,
                    output entries_after, input ready);
    modport sink   (input valid, input popped_value, input status,
                    input entries_after, output ready);
endinterface

interface hmq_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [hmq_pkg::CAP_W-1:0]             data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/binary_min_heap_queue_core.sv
// Binary min-heap queue: sequencer over one heap RAM and one shared comparator.
// Push: writes at the tail, then sifts up through check and compare states per level, stopping at the root.
// Pop: reads the top and the tail, then sifts down, ending at a leaf; full or empty go straight to the result.
// One item in flight; the next is taken once the result is in the output register.
// Synchronous active-low reset clears the count, state and output valid; capacity
// returns to 64. Heap contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module binary_min_heap_queue_core #(
    parameter int DEPTH = hmq_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hmq_in_if.sink    i_in,
    hmq_cfg_if.sink   i_cfg,
    hmq_out_if.source o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > hmq_pkg::CAP_W) ? CW : hmq_pkg::CAP_W;
    localparam int XW = AW + 2;
    localparam int VW = hmq_pkg::VALUE_W;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_PU_CHK  = 10'b00_0000_0010,
        S_PU_CMP  = 10'b00_0000_0100,
        S_PO_TOP  = 10'b00_0000_1000,
        S_PO_TAIL = 10'b00_0001_0000,
        S_PO_CHK  = 10'b00_0010_0000,
        S_PO_RDL  = 10'b00_0100_0000,
        S_PO_RDR  = 10'b00_1000_0000,
        S_PO_CMP  = 10'b01_0000_0000,
        S_FIN     = 10'b10_0000_0000
    } t_state;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [hmq_pkg::CAP_W-1:0]  r_cap, n_cap;
    logic [AW-1:0]              r_pos, n_pos;
    logic [AW-1:0]              r_cidx, n_cidx;
    logic signed [VW-1:0]       r_val, n_val;
    logic signed [VW-1:0]       r_child, n_child;
    logic signed [VW-1:0]       r_popped, n_popped;
    hmq_pkg::t_status           r_status, n_status;

    logic                       r_out_valid, n_out_valid;
    logic signed [VW-1:0]       r_out_popped, n_out_popped;
    hmq_pkg::t_status           r_out_status, n_out_status;
    logic [CW-1:0]              r_out_count, n_out_count;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic signed [VW-1:0]       ram_wdata, ram_rdata;
    logic signed [VW-1:0]       cmp_a, cmp_b;
    logic                       cmp_lt;

    logic                       in_xfer, heap_full;
    logic [AW-1:0]              pos_m1, parent;
    logic [XW-1:0]              lchild, rchild, count_x;

    hmq_ram #(.DEPTH(DEPTH), .W(VW), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    hmq_lt #(.W(VW)) u_lt (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_lt (cmp_lt)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_xfer     = i_in.valid && i_in.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.popped_value  = r_out_popped;
    assign o_out.status        = r_out_status;
    assign o_out.entries_after = r_out_count;

    assign heap_full = (EW'(r_count) >= EW'(r_cap)) || (EW'(r_count) >= EW'(DEPTH));
    assign pos_m1    = r_pos - AW'(1);
    assign parent    = pos_m1 >> 1;
    assign lchild    = (XW'(r_pos) << 1) + XW'(1);
    assign rchild    = XW'(r_cidx) + XW'(1);
    assign count_x   = XW'(r_count);

    always_comb begin
        cmp_a = r_val;
        cmp_b = ram_rdata;
        case (r_state)
            S_PO_RDR: begin
                cmp_a = ram_rdata;
                cmp_b = r_child;
            end
            S_PO_CMP: begin
                cmp_a = r_child;
                cmp_b = r_val;
            end
            default: begin
                cmp_a = r_val;
                cmp_b = ram_rdata;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cap        = r_cap;
        n_pos        = r_pos;
        n_cidx       = r_cidx;
        n_val        = r_val;
        n_child      = r_child;
        n_popped     = r_popped;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_popped = r_out_popped;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = r_pos;
        ram_wdata    = r_val;
        ram_raddr    = '0;

        if (i_cfg.valid) begin
            n_cap = i_cfg.data;
        end
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_popped = hmq_pkg::INT_MIN;
                    n_status = hmq_pkg::ST_DONE;
                    if (i_in.kind == hmq_pkg::KIND_PUSH) begin
                        if (heap_full) begin
                            n_status = hmq_pkg::ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_val   = i_in.value;
                            n_pos   = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                            n_state = S_PU_CHK;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = hmq_pkg::ST_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            n_count   = r_count - CW'(1);
                            ram_raddr = '0;
                            n_state   = S_PO_TOP;
                        end
                    end
                end
            end
            S_PU_CHK: begin
                if (r_pos == '0) begin
                    ram_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    ram_raddr = parent;
                    n_state   = S_PU_CMP;
                end
            end
            S_PU_CMP: begin
                ram_we = 1'b1;
                if (cmp_lt) begin
                    ram_wdata = ram_rdata;
                    n_pos     = parent;
                    n_state   = S_PU_CHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_PO_TOP: begin
                n_popped  = ram_rdata;
                ram_raddr = r_count[AW-1:0];
                n_state   = S_PO_TAIL;
            end
            S_PO_TAIL: begin
                n_val   = ram_rdata;
                n_pos   = '0;
                n_state = S_PO_CHK;
            end
            S_PO_CHK: begin
                if (lchild >= count_x) begin
                    ram_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    ram_raddr = lchild[AW-1:0];
                    n_cidx    = lchild[AW-1:0];
                    n_state   = S_PO_RDL;
                end
            end
            S_PO_RDL: begin
                n_child = ram_rdata;
                if (rchild < count_x) begin
                    ram_raddr = rchild[AW-1:0];
                    n_state   = S_PO_RDR;
                end else begin
                    n_state = S_PO_CMP;
                end
            end
            S_PO_RDR: begin
                if (cmp_lt) begin
                    n_child = ram_rdata;
                    n_cidx  = rchild[AW-1:0];
                end
                n_state = S_PO_CMP;
            end
            S_PO_CMP: begin
                ram_we = 1'b1;
                if (cmp_lt) begin
                    ram_wdata = r_child;
                    n_pos     = r_cidx;
                    n_state   = S_PO_CHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_popped = r_popped;
                    n_out_status = r_status;
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap       <= hmq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
        r_pos        <= n_pos;
        r_cidx       <= n_cidx;
        r_val        <= n_val;
        r_child      <= n_child;
        r_popped     <= n_popped;
        r_status     <= n_status;
        r_out_popped <= n_out_popped;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

endmodule

>>> rtl/hmq_ram.sv
// Heap storage: one write port, one read port with registered read data.
// Depends on hmq_pkg for the default word width.
`timescale 1ns / 1ps

module hmq_ram #(
    parameter int DEPTH = hmq_pkg::DEPTH_DEF,
    parameter int W     = hmq_pkg::VALUE_W,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic signed [W-1:0] i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output logic signed [W-1:0] o_rdata
);

    logic signed [W-1:0] r_mem [DEPTH];
    logic signed [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/hmq_lt.sv
// Shared signed less-than comparator used by every sift step.
// Depends on hmq_pkg for the default word width.
`timescale 1ns / 1ps

module hmq_lt #(
    parameter int W = hmq_pkg::VALUE_W
) (
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic                o_lt
);

    assign o_lt = (i_a < i_b);

endmodule
